@@ rtl/fpr_pkg.sv @@
// Shared types and constants for the frame pattern replace block.
// Used by fpr_cell and frame_pattern_replace; depends on nothing.
`default_nettype none

package fpr_pkg;

	localparam int ByteW  = 8;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;
	localparam int PatBytes = 8;
	localparam int MacBytes = 12;
	localparam int PosW = 4;

	typedef enum logic [CfgIdxW-1:0] {
		REG_PATTERN     = 3'd0,
		REG_REPLACEMENT = 3'd1,
		REG_LENGTH      = 3'd2,
		REG_POLICY_PORT = 3'd3,
		REG_DEST_MAC    = 3'd4,
		REG_SOURCE_MAC  = 3'd5
	} cfg_reg_t;

	localparam logic [47:0] DestMacReset   = 48'h5254_0020_0082;
	localparam logic [47:0] SourceMacReset = 48'h5254_0030_0082;

	// Per-cycle control that the top level hands to every window cell.
	typedef struct packed {
		logic shift;
		logic replace;
	} cell_ctrl_t;

	// Header byte at a given output position; byte 0 is the top byte of the destination.
	function automatic logic [ByteW-1:0] mac_byte(input logic [47:0] dst,
	                                             input logic [47:0] src,
	                                             input logic [PosW-1:0] pos);
		logic [ByteW-1:0] b;
		b = '0;
		case (pos)
			4'd0:  b = dst[47:40];
			4'd1:  b = dst[39:32];
			4'd2:  b = dst[31:24];
			4'd3:  b = dst[23:16];
			4'd4:  b = dst[15:8];
			4'd5:  b = dst[7:0];
			4'd6:  b = src[47:40];
			4'd7:  b = src[39:32];
			4'd8:  b = src[31:24];
			4'd9:  b = src[23:16];
			4'd10: b = src[15:8];
			4'd11: b = src[7:0];
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

@@ rtl/frame_pattern_replace.sv @@
// A byte enters the output register when the request that lets it go is accepted,
// pattern_length-1 requests after its own; throughput is one byte per cycle while the
// output does not stall and no frame end drains. The last byte of a frame holds the input
// while the window drains, one byte per cycle through the single output register unless it stalls.
// Reset clears window count, header position, handshake state; config takes its defaults.
// Depends on fpr_pkg and fpr_cell.
`default_nettype none

module frame_pattern_replace #(
	parameter int WINDOW_MAX = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [fpr_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [fpr_pkg::CfgDataW-1:0] cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [7:0]                   frame_byte,
	input  wire logic [3:0]                   ingress_port,
	input  wire logic                         last_byte,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [7:0]                        out_byte,
	output logic                              out_last
);

	localparam int LW     = $clog2(WINDOW_MAX + 1);
	localparam int LenMax = (WINDOW_MAX < fpr_pkg::PatBytes) ? WINDOW_MAX : fpr_pkg::PatBytes;
	localparam int BW     = fpr_pkg::ByteW;

	// Configuration registers.
	logic [63:0] pattern_q;
	logic [63:0] replacement_q;
	logic [3:0]  length_q;
	logic [3:0]  policy_port_q;
	logic [47:0] dest_mac_q;
	logic [47:0] source_mac_q;

	// Window control.
	logic [LW-1:0]            fill_q;
	logic [fpr_pkg::PosW-1:0] pos_q;
	logic                     pend_q;
	logic                     pport_q;
	logic                     plast_q;

	logic                     out_valid_q;
	logic [BW-1:0]            out_byte_q;
	logic                     out_last_q;

	logic [LW-1:0]            len_eff;
	logic                     accept;
	logic                     active;
	logic                     port_sel;
	logic                     last_sel;
	logic                     emit_ok;
	logic [LW-1:0]            fill_a;
	logic [LW-1:0]            fill_n;
	logic                     need_a;
	logic                     need_n;
	logic                     emit;
	logic                     all_eq;
	logic                     emit_last;
	logic [BW-1:0]            emit_byte;
	fpr_pkg::cell_ctrl_t      ctrl;

	logic [WINDOW_MAX-1:0]    cell_eq;
	logic [BW-1:0]            cell_repl [WINDOW_MAX];

	always_comb begin
		if (length_q == 4'd0) begin
			len_eff = LW'(1);
		end else if (int'(length_q) > LenMax) begin
			len_eff = LW'(LenMax);
		end else begin
			len_eff = LW'(length_q);
		end
	end

	assign emit_ok  = !out_valid_q || !out_stall;
	assign in_stall = pend_q || !emit_ok;
	assign accept   = in_valid && !in_stall;
	assign active   = accept || pend_q;
	assign port_sel = accept ? (ingress_port == policy_port_q) : pport_q;
	assign last_sel = accept ? last_byte : plast_q;
	assign all_eq   = &cell_eq;

	always_comb begin
		fill_a    = accept ? fill_q + LW'(1) : fill_q;
		// Bytes are tested while the window is full; on the last byte the rest drains untested.
		need_a    = (fill_a >= len_eff) || (last_sel && fill_a != '0);
		emit      = active && need_a && emit_ok;
		fill_n    = emit ? fill_a - LW'(1) : fill_a;
		need_n    = (fill_n >= len_eff) || (last_sel && fill_n != '0);
		ctrl.shift   = emit;
		ctrl.replace = emit && (fill_a >= len_eff) && port_sel && all_eq;
		emit_last = last_sel && (fill_a == LW'(1));
		emit_byte = (pos_q < 4'(fpr_pkg::MacBytes)) ?
		            fpr_pkg::mac_byte(dest_mac_q, source_mac_q, pos_q) : cell_repl[0];
	end

	for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
		logic [BW-1:0] pat_k;
		logic [BW-1:0] rep_k;
		logic [BW-1:0] right_k;

		if (k < fpr_pkg::PatBytes) begin : g_pat
			assign pat_k = pattern_q[BW*k +: BW];
			assign rep_k = replacement_q[BW*k +: BW];
		end else begin : g_nopat
			assign pat_k = '0;
			assign rep_k = '0;
		end

		if (k == WINDOW_MAX - 1) begin : g_end
			assign right_k = '0;
		end else begin : g_mid
			assign right_k = cell_repl[k+1];
		end

		fpr_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.load       (accept && (fill_q == LW'(k))),
			.in_byte    (frame_byte),
			.pat_byte   (pat_k),
			.rep_byte   (rep_k),
			.in_use     (len_eff > LW'(k)),
			.right_byte (right_k),
			.eq         (cell_eq[k]),
			.repl_byte  (cell_repl[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q     <= '0;
			replacement_q <= '0;
			length_q      <= 4'd1;
			policy_port_q <= '0;
			dest_mac_q    <= fpr_pkg::DestMacReset;
			source_mac_q  <= fpr_pkg::SourceMacReset;
		end else if (cfg_we) begin
			case (cfg_index)
				fpr_pkg::REG_PATTERN:     pattern_q     <= cfg_data;
				fpr_pkg::REG_REPLACEMENT: replacement_q <= cfg_data;
				fpr_pkg::REG_LENGTH:      length_q      <= cfg_data[3:0];
				fpr_pkg::REG_POLICY_PORT: policy_port_q <= cfg_data[3:0];
				fpr_pkg::REG_DEST_MAC:    dest_mac_q    <= cfg_data[47:0];
				fpr_pkg::REG_SOURCE_MAC:  source_mac_q  <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			pos_q       <= '0;
			pend_q      <= 1'b0;
			pport_q     <= 1'b0;
			plast_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_n;
			pend_q <= active && need_n;
			if (accept) begin
				pport_q <= port_sel;
				plast_q <= last_byte;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				if (emit_last) begin
					pos_q <= '0;
				end else if (pos_q < 4'(fpr_pkg::MacBytes)) begin
					pos_q <= pos_q + 4'd1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

@@ rtl/fpr_cell.sv @@
// One byte cell of the delay window: load, compare, overwrite and shift left.
// Depends on fpr_pkg for the cell control struct.
`default_nettype none

module fpr_cell (
	input  wire logic                      clk,
	input  wire fpr_pkg::cell_ctrl_t       ctrl,
	input  wire logic                      load,
	input  wire logic [fpr_pkg::ByteW-1:0] in_byte,
	input  wire logic [fpr_pkg::ByteW-1:0] pat_byte,
	input  wire logic [fpr_pkg::ByteW-1:0] rep_byte,
	input  wire logic                      in_use,
	input  wire logic [fpr_pkg::ByteW-1:0] right_byte,
	output logic                           eq,
	output logic [fpr_pkg::ByteW-1:0]      repl_byte
);

	logic [fpr_pkg::ByteW-1:0] byte_q;
	logic [fpr_pkg::ByteW-1:0] cur;

	always_comb begin
		cur       = load ? in_byte : byte_q;
		// Cells past the pattern length never block a match.
		eq        = !in_use || (cur == pat_byte);
		repl_byte = (ctrl.replace && in_use) ? rep_byte : cur;
	end

	always_ff @(posedge clk) begin
		byte_q <= ctrl.shift ? right_byte : repl_byte;
	end

endmodule

`default_nettype wire

@@ rtl/fpr_checker.sv @@
// Port-level checks for frame_pattern_replace, attached by the bind at the end.
// Depends only on the handshake and output ports of frame_pattern_replace.
`default_nettype none

module fpr_checker #(
	parameter int WINDOW_MAX = 8
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [7:0]                   out_byte,
	input wire logic                         out_last
);

	localparam int CW = $clog2(WINDOW_MAX + 3);

	// Bytes accepted at the input and not yet delivered at the output.
	logic [CW-1:0] held_q;
	logic          in_acc;
	logic          out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else begin
			held_q <= held_q + CW'(in_acc) - CW'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output request changed while stalled");

	a_out_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> held_q != '0)
		else $error("output delivered with no input byte outstanding");

	a_rise_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> held_q != '0)
		else $error("output request raised with no input byte outstanding");

	a_idle_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == '0 && !out_valid |-> !in_stall)
		else $error("input stalled while the block is empty");

endmodule

bind frame_pattern_replace fpr_checker #(.WINDOW_MAX(WINDOW_MAX)) u_fpr_checker (.*);

`default_nettype wire
